>>> src/skt_pkg.sv
// Shared types and constants for the sorted keyed table.
// Used by skt_ram's instantiating top level, sorted_keyed_table.
package skt_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_DELETE,
    MODE_MODIFY,
    MODE_LOOKUP
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DUP,
    ST_MISSING,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] price;
    logic [15:0] qty;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sorted_keyed_table.sv
// Top level of the sorted keyed table: sequencer, search and shift datapath.
// Depends on skt_pkg and skt_ram.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------------
//   input    | start & !busy            | in_mode, in_key, in_price_cents, in_quantity
//   result   | out_valid (one cycle)    | out_status, out_found_index, out_entry_total,
//            |                          | out_found_price, out_found_quantity
//
// Busy covers the search, which stops at the first entry whose key is not below in_key
// or past the last entry; the decide state; the shift state for insert or delete; and
// the write state for insert or modify. The result follows the last of these.
// Reset is synchronous and clears the entry count; RAM contents are not cleared.
// The result is pulsed for one cycle; the receiver cannot stall it.
module sorted_keyed_table
  import skt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_price_cents,
  input  logic [15:0] in_quantity,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_found_index,
  output logic [6:0]  out_entry_total,
  output logic [31:0] out_found_price,
  output logic [15:0] out_found_quantity
);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  mode_t         mode_r, mode_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   price_r, price_nxt;
  logic [15:0]   qty_r, qty_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   fp_r, fp_nxt;
  logic [15:0]   fq_r, fq_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [CW-1:0] moves_r, moves_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [5:0]    out_index_r, out_index_nxt;
  logic [6:0]    out_total_r, out_total_nxt;
  logic [31:0]   out_price_r, out_price_nxt;
  logic [15:0]   out_qty_r, out_qty_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  logic          key_ge;
  logic          key_eq;
  logic          search_done;
  logic          table_full;
  logic          shift_end;

  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_ge      = ram_rdata.key >= key_r;
  assign key_eq      = ram_rdata.key == key_r;
  assign search_done = pend_r ? (key_ge || (idx_r >= count_r)) : (count_r == '0);
  assign table_full  = count_r == CW'(DEPTH);
  assign shift_end   = (moves_r == '0) && !pend_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (search_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (mode_r)
          MODE_INSERT: state_nxt = (found_r || table_full) ? S_IDLE : S_SHIFT;
          MODE_DELETE: state_nxt = found_r ? S_SHIFT : S_IDLE;
          MODE_MODIFY: state_nxt = found_r ? S_WRITE : S_IDLE;
          MODE_LOOKUP: state_nxt = S_IDLE;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_SHIFT: begin
        if (shift_end) state_nxt = (mode_r == MODE_INSERT) ? S_WRITE : S_IDLE;
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    price_nxt      = price_r;
    qty_nxt        = qty_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    fp_nxt         = fp_r;
    fq_nxt         = fq_r;
    src_nxt        = src_r;
    prev_nxt       = prev_r;
    moves_nxt      = moves_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_total_nxt  = out_total_r;
    out_price_nxt  = out_price_r;
    out_qty_nxt    = out_qty_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(pos_r);
    ram_wdata      = '{key: key_r, price: price_r, qty: qty_r};
    ram_raddr      = AW'(idx_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = mode_t'(in_mode);
          key_nxt   = in_key;
          price_nxt = in_price_cents;
          qty_nxt   = in_quantity;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
        end
      end
      S_SEARCH: begin
        if (search_done) begin
          pend_nxt  = 1'b0;
          found_nxt = pend_r && key_eq;
          if (!pend_r) begin
            pos_nxt = '0;
          end else if (key_ge) begin
            pos_nxt = CW'(idx_r - 1'b1);
          end else begin
            pos_nxt = idx_r;
          end
          fp_nxt = ram_rdata.price;
          fq_nxt = ram_rdata.qty;
        end else begin
          idx_nxt  = CW'(idx_r + 1'b1);
          pend_nxt = 1'b1;
        end
      end
      S_DECIDE: begin
        out_total_nxt = 7'(count_r);
        out_price_nxt = '0;
        out_qty_nxt   = '0;
        if (mode_r == MODE_INSERT) begin
          src_nxt   = AW'(count_r - 1'b1);
          moves_nxt = CW'(count_r - pos_r);
          if (found_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DUP;
            out_index_nxt  = 6'(pos_r);
          end else if (table_full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            out_index_nxt  = '0;
          end
        end else if (!found_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISSING;
          out_index_nxt  = '0;
        end else if (mode_r == MODE_DELETE) begin
          src_nxt   = AW'(pos_r + 1'b1);
          moves_nxt = CW'(count_r - pos_r - 1'b1);
        end else if (mode_r == MODE_LOOKUP) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_index_nxt  = 6'(pos_r);
          out_price_nxt  = fp_r;
          out_qty_nxt    = fq_r;
        end
      end
      S_SHIFT: begin
        ram_wdata = ram_rdata;
        ram_waddr = (mode_r == MODE_INSERT) ? AW'(prev_r + 1'b1) : AW'(prev_r - 1'b1);
        ram_raddr = src_r;
        ram_we    = pend_r;
        if (moves_r != '0) begin
          prev_nxt  = src_r;
          src_nxt   = (mode_r == MODE_INSERT) ? AW'(src_r - 1'b1) : AW'(src_r + 1'b1);
          moves_nxt = CW'(moves_r - 1'b1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (shift_end && (mode_r == MODE_DELETE)) begin
          count_nxt      = CW'(count_r - 1'b1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_index_nxt  = 6'(pos_r);
          out_total_nxt  = 7'(CW'(count_r - 1'b1));
        end
      end
      S_WRITE: begin
        ram_we         = 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_index_nxt  = 6'(pos_r);
        if (mode_r == MODE_INSERT) begin
          count_nxt     = CW'(count_r + 1'b1);
          out_total_nxt = 7'(CW'(count_r + 1'b1));
        end else begin
          out_total_nxt = 7'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      moves_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      moves_r     <= moves_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    price_r      <= price_nxt;
    qty_r        <= qty_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    fp_r         <= fp_nxt;
    fq_r         <= fq_nxt;
    src_r        <= src_nxt;
    prev_r       <= prev_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_total_r  <= out_total_nxt;
    out_price_r  <= out_price_nxt;
    out_qty_r    <= out_qty_nxt;
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_index    = out_index_r;
  assign out_entry_total    = out_total_r;
  assign out_found_price    = out_price_r;
  assign out_found_quantity = out_qty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result issued while still busy");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid)
    else $error("entry count changed without a result");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (count_r == CW'(DEPTH)))
    else $error("full status with free slots");

endmodule

>>> tb/sv/tb_sorted_keyed_table.sv
// Self-checking testbench for sorted_keyed_table: directed and random insert, delete,
// modify and lookup transactions, checked against a scoreboard that mirrors the table.
// Depends on skt_pkg and the sorted_keyed_table RTL.
`timescale 1ns / 1ps

module tb_sorted_keyed_table;
  import skt_pkg::*;

  typedef struct {
    status_t     status;
    logic [5:0]  index;
    logic [6:0]  total;
    logic [31:0] price;
    logic [15:0] qty;
  } skt_result_t;

  class skt_scoreboard;
    logic [31:0] keys [DEPTH];
    logic [31:0] prices [DEPTH];
    logic [15:0] qtys [DEPTH];
    int unsigned count = 0;
    int unsigned failures = 0;
    skt_result_t result_q [$];

    function int find_key(logic [31:0] k);
      for (int i = 0; i < count; i++) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    function void note_request(mode_t m, logic [31:0] k, logic [31:0] p, logic [15:0] q);
      skt_result_t r;
      int pos;
      int i;
      pos = find_key(k);
      r.status = ST_OK;
      r.index = '0;
      r.price = '0;
      r.qty = '0;
      if (m == MODE_INSERT) begin
        if (pos >= 0) begin
          r.status = ST_DUP;
          r.index = pos[5:0];
        end else if (count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          i = count;
          while (i > 0 && keys[i-1] > k) begin
            keys[i] = keys[i-1];
            prices[i] = prices[i-1];
            qtys[i] = qtys[i-1];
            i--;
          end
          keys[i] = k;
          prices[i] = p;
          qtys[i] = q;
          count++;
          r.index = i[5:0];
        end
      end else if (pos < 0) begin
        r.status = ST_MISSING;
      end else begin
        r.index = pos[5:0];
        if (m == MODE_DELETE) begin
          for (i = pos; i + 1 < count; i++) begin
            keys[i] = keys[i+1];
            prices[i] = prices[i+1];
            qtys[i] = qtys[i+1];
          end
          count--;
        end else if (m == MODE_MODIFY) begin
          prices[pos] = p;
          qtys[pos] = q;
        end else begin
          r.price = prices[pos];
          r.qty = qtys[pos];
        end
      end
      r.total = count[6:0];
      result_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [5:0] index, logic [6:0] total,
                               logic [31:0] price, logic [15:0] qty);
      skt_result_t r;
      if (result_q.size() == 0) begin
        $error("unexpected result transaction: status %0d index %0d", status, index);
        failures++;
        return;
      end
      r = result_q.pop_front();
      if (status !== r.status) begin
        $error("out_status: expected %0d, actual %0d", r.status, status);
        failures++;
      end
      if (index !== r.index) begin
        $error("out_found_index: expected %0d, actual %0d", r.index, index);
        failures++;
      end
      if (total !== r.total) begin
        $error("out_entry_total: expected %0d, actual %0d", r.total, total);
        failures++;
      end
      if (price !== r.price) begin
        $error("out_found_price: expected %0h, actual %0h", r.price, price);
        failures++;
      end
      if (qty !== r.qty) begin
        $error("out_found_quantity: expected %0h, actual %0h", r.qty, qty);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_price_cents = '0;
  logic [15:0] in_quantity = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_found_index;
  logic [6:0]  out_entry_total;
  logic [31:0] out_found_price;
  logic [15:0] out_found_quantity;

  skt_scoreboard sb;
  bit filling = 1'b1;

  sorted_keyed_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_key             (in_key),
    .in_price_cents     (in_price_cents),
    .in_quantity        (in_quantity),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_index    (out_found_index),
    .out_entry_total    (out_entry_total),
    .out_found_price    (out_found_price),
    .out_found_quantity (out_found_quantity)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_status, out_found_index, out_entry_total, out_found_price,
                      out_found_quantity);
    end
  end

  task automatic send_request(input mode_t m, input logic [31:0] k, input logic [31:0] p,
                              input logic [15:0] q, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_key <= k;
    in_price_cents <= p;
    in_quantity <= q;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(m, k, p, q);
  endtask

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(20, 180);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [31:0] pick_key(bit hit);
    if (hit && sb.count > 0) return sb.keys[$urandom_range(0, sb.count - 1)];
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(0, 255);
      5: return (sb.count > 0) ? sb.keys[$urandom_range(0, sb.count - 1)] + 32'd1 : $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_price();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned pct);
    mode_t m;
    int unsigned r;
    bit hit;
    for (int unsigned j = 0; j < n; j++) begin
      if (sb.count >= DEPTH && $urandom_range(0, 99) < 12) filling = 1'b0;
      if (sb.count <= 2) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (filling) begin
        m = (r < 65) ? MODE_INSERT : (r < 75) ? MODE_DELETE : (r < 88) ? MODE_MODIFY
                                                                      : MODE_LOOKUP;
      end else begin
        m = (r < 15) ? MODE_INSERT : (r < 65) ? MODE_DELETE : (r < 80) ? MODE_MODIFY
                                                                      : MODE_LOOKUP;
      end
      hit = (m == MODE_INSERT) ? ($urandom_range(0, 99) < 30) : ($urandom_range(0, 99) < 75);
      send_request(m, pick_key(hit), pick_price(), 16'($urandom_range(0, 65535)),
                   pick_gap(pct));
    end
  endtask

  initial begin
    #30000000;
    $display("tb_sorted_keyed_table NOT OK");
    $finish;
  end

  initial begin
    sb = new;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_request(MODE_INSERT, 32'h8000_0000, 32'd1234, 16'd5, 0);
    send_request(MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 16'h0, 3);
    send_request(MODE_INSERT, 32'd5, 32'hA5A5_5A5A, 16'h5A5A, 0);
    send_request(MODE_INSERT, 32'h8000_0000, 32'd1, 16'd1, 7);
    send_request(MODE_LOOKUP, 32'h0, 32'd0, 16'd0, 0);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h5555_5555, 16'hAAAA, 1);
    send_request(MODE_LOOKUP, 32'd5, 32'd0, 16'd0, 0);
    send_request(MODE_LOOKUP, 32'd7, 32'd0, 16'd0, 40);
    send_request(MODE_MODIFY, 32'd5, 32'hFFFF_FFFF, 16'hFFFF, 0);
    send_request(MODE_LOOKUP, 32'd5, 32'd0, 16'd0, 2);
    send_request(MODE_MODIFY, 32'd9, 32'd77, 16'd77, 0);
    send_request(MODE_DELETE, 32'd9, 32'd0, 16'd0, 0);
    send_request(MODE_DELETE, 32'd5, 32'd0, 16'd0, 5);
    send_request(MODE_DELETE, 32'h0, 32'd0, 16'd0, 0);
    send_request(MODE_DELETE, 32'hFFFF_FFFF, 32'd0, 16'd0, 0);
    send_request(MODE_LOOKUP, 32'h8000_0000, 32'd0, 16'd0, 9);
    send_request(MODE_DELETE, 32'h8000_0000, 32'd0, 16'd0, 0);
    send_request(MODE_LOOKUP, 32'h8000_0000, 32'd0, 16'd0, 0);
    send_request(MODE_DELETE, 32'h0, 32'd0, 16'd0, 0);
    send_request(MODE_MODIFY, 32'hFFFF_FFFF, 32'd0, 16'd0, 0);

    run_random(600, 0);
    run_random(550, 85);
    run_random(550, 8);
    start <= 1'b0;

    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (sb.failures == 0 && sb.result_q.size() == 0) begin
      $display("tb_sorted_keyed_table OK");
    end else begin
      $display("tb_sorted_keyed_table NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
src/skt_pkg.sv
src/skt_ram.sv
src/sorted_keyed_table.sv
tb/sv/tb_sorted_keyed_table.sv
